FILE: src/iqpm_pkg.sv
// Shared types and constants for the I/Q peak and mean power meter.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package iqpm_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int POWER_BITS  = 31;
   localparam int COUNT_BITS  = 27;
   localparam int SUM_BITS    = POWER_BITS + COUNT_BITS - 1;
   localparam int LIMIT_BITS  = 26;
   localparam int JOB_DEPTH   = 2;
   localparam int STEP_BITS   = $clog2(SUM_BITS);

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(4096000);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] i_sample;
      logic signed [SAMPLE_BITS-1:0] q_sample;
   } req_type;

   typedef struct packed {
      logic [POWER_BITS-1:0] i_peak_power;
      logic [POWER_BITS-1:0] q_peak_power;
      logic [POWER_BITS-1:0] i_mean_power;
      logic [POWER_BITS-1:0] q_mean_power;
      logic [COUNT_BITS-1:0] window_count;
   } rsp_type;

   // One closed window on its way from the accumulators to the divider.
   typedef struct packed {
      logic [POWER_BITS-1:0] i_peak;
      logic [POWER_BITS-1:0] q_peak;
      logic [SUM_BITS-1:0]   i_sum;
      logic [SUM_BITS-1:0]   q_sum;
      logic [COUNT_BITS-1:0] count;
   } job_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_DONE
   } back_state_type;

endpackage
`default_nettype wire

FILE: src/iqpm_front.sv
// Front end: squares each I/Q sample, keeps sums, peaks and the sample count,
// and hands each closed window to the job queue. Depends on iqpm_pkg.
`default_nettype none
module iqpm_front import iqpm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_word,
   input  logic [LIMIT_BITS-1:0] window_limit,
   input  logic                  job_full,
   output logic                  job_push,
   output job_type               job_word
);

   logic signed [2*SAMPLE_BITS-1:0] i_prod;
   logic signed [2*SAMPLE_BITS-1:0] q_prod;

   logic                  s1_valid_ff, s1_valid_in;
   logic [POWER_BITS-1:0] i_sq_ff, i_sq_in;
   logic [POWER_BITS-1:0] q_sq_ff, q_sq_in;
   logic [SUM_BITS-1:0]   i_sum_ff, i_sum_in;
   logic [SUM_BITS-1:0]   q_sum_ff, q_sum_in;
   logic [POWER_BITS-1:0] i_peak_ff, i_peak_in;
   logic [POWER_BITS-1:0] q_peak_ff, q_peak_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic [COUNT_BITS-1:0] count_next;
   logic [SUM_BITS-1:0]   i_sum_next, q_sum_next;
   logic [POWER_BITS-1:0] i_peak_next, q_peak_next;
   logic                  closing;
   logic                  advance;

   assign i_prod = req_word.i_sample * req_word.i_sample;
   assign q_prod = req_word.q_sample * req_word.q_sample;

   assign count_next  = count_ff + 1'b1;
   assign closing     = count_next > COUNT_BITS'(window_limit);
   assign i_sum_next  = i_sum_ff + SUM_BITS'(i_sq_ff);
   assign q_sum_next  = q_sum_ff + SUM_BITS'(q_sq_ff);
   assign i_peak_next = (i_sq_ff > i_peak_ff) ? i_sq_ff : i_peak_ff;
   assign q_peak_next = (q_sq_ff > q_peak_ff) ? q_sq_ff : q_peak_ff;

   // The whole front moves together; it only waits when a window closes
   // and the job queue has no room for it.
   assign advance  = !(s1_valid_ff && closing && job_full);
   assign req_full = !advance;
   assign job_push = s1_valid_ff && closing && !job_full;

   assign job_word = '{i_peak: i_peak_next, q_peak: q_peak_next,
                       i_sum: i_sum_next, q_sum: q_sum_next, count: count_next};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      i_sq_in     = i_sq_ff;
      q_sq_in     = q_sq_ff;
      i_sum_in    = i_sum_ff;
      q_sum_in    = q_sum_ff;
      i_peak_in   = i_peak_ff;
      q_peak_in   = q_peak_ff;
      count_in    = count_ff;
      if (advance) begin
         s1_valid_in = req_push;
         i_sq_in     = i_prod[POWER_BITS-1:0];
         q_sq_in     = q_prod[POWER_BITS-1:0];
         if (s1_valid_ff) begin
            if (closing) begin
               i_sum_in  = '0;
               q_sum_in  = '0;
               i_peak_in = '0;
               q_peak_in = '0;
               count_in  = '0;
            end else begin
               i_sum_in  = i_sum_next;
               q_sum_in  = q_sum_next;
               i_peak_in = i_peak_next;
               q_peak_in = q_peak_next;
               count_in  = count_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         i_sum_ff    <= '0;
         q_sum_ff    <= '0;
         i_peak_ff   <= '0;
         q_peak_ff   <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         i_sum_ff    <= i_sum_in;
         q_sum_ff    <= q_sum_in;
         i_peak_ff   <= i_peak_in;
         q_peak_ff   <= q_peak_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      i_sq_ff <= i_sq_in;
      q_sq_ff <= q_sq_in;
   end

endmodule
`default_nettype wire

FILE: src/iqpm_job_fifo.sv
// Short queue of closed windows between the front end and the divider.
// Depends on iqpm_pkg.
`default_nettype none
module iqpm_job_fifo import iqpm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_word,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type pop_word
);

   localparam int PTR_BITS = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;

   job_type mem [JOB_DEPTH];

   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]     fill_ff, fill_in;
   logic                  do_push, do_pop;

   assign full     = fill_ff == (PTR_BITS+1)'(JOB_DEPTH);
   assign empty    = fill_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(JOB_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(JOB_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_word;
      end
   end

endmodule
`default_nettype wire

FILE: src/iqpm_divider.sv
// Back end: takes a closed window from the job queue and divides both power
// sums by the sample count, one quotient bit per cycle. Depends on iqpm_pkg.
`default_nettype none
module iqpm_divider import iqpm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_empty,
   output logic    job_pop,
   input  job_type job_word,
   input  logic    out_ready,
   output logic    out_load,
   output rsp_type out_word
);

   back_state_type state_ff, state_in;

   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [COUNT_BITS-1:0] div_ff, div_in;
   logic [COUNT_BITS-1:0] i_rem_ff, i_rem_in;
   logic [COUNT_BITS-1:0] q_rem_ff, q_rem_in;
   logic [SUM_BITS-1:0]   i_quo_ff, i_quo_in;
   logic [SUM_BITS-1:0]   q_quo_ff, q_quo_in;
   logic [POWER_BITS-1:0] i_peak_ff, i_peak_in;
   logic [POWER_BITS-1:0] q_peak_ff, q_peak_in;

   logic [COUNT_BITS:0]   i_trial, q_trial;
   logic [COUNT_BITS:0]   i_diff, q_diff;
   logic                  i_fits, q_fits;

   // Restoring division: the remainder always stays below the divisor, so
   // the shifted trial value needs just one extra bit.
   assign i_trial = {i_rem_ff, i_quo_ff[SUM_BITS-1]};
   assign q_trial = {q_rem_ff, q_quo_ff[SUM_BITS-1]};
   assign i_fits  = i_trial >= {1'b0, div_ff};
   assign q_fits  = q_trial >= {1'b0, div_ff};
   assign i_diff  = i_trial - {1'b0, div_ff};
   assign q_diff  = q_trial - {1'b0, div_ff};

   assign out_word = '{i_peak_power: i_peak_ff, q_peak_power: q_peak_ff,
                       i_mean_power: i_quo_ff[POWER_BITS-1:0],
                       q_mean_power: q_quo_ff[POWER_BITS-1:0],
                       window_count: div_ff};

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      div_in    = div_ff;
      i_rem_in  = i_rem_ff;
      q_rem_in  = q_rem_ff;
      i_quo_in  = i_quo_ff;
      q_quo_in  = q_quo_ff;
      i_peak_in = i_peak_ff;
      q_peak_in = q_peak_ff;
      job_pop   = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            if (!job_empty) begin
               job_pop   = 1'b1;
               step_in   = '0;
               div_in    = job_word.count;
               i_rem_in  = '0;
               q_rem_in  = '0;
               i_quo_in  = job_word.i_sum;
               q_quo_in  = job_word.q_sum;
               i_peak_in = job_word.i_peak;
               q_peak_in = job_word.q_peak;
               state_in  = BACK_DIVIDE;
            end
         end
         BACK_DIVIDE: begin
            i_rem_in = i_fits ? i_diff[COUNT_BITS-1:0] : i_trial[COUNT_BITS-1:0];
            q_rem_in = q_fits ? q_diff[COUNT_BITS-1:0] : q_trial[COUNT_BITS-1:0];
            i_quo_in = {i_quo_ff[SUM_BITS-2:0], i_fits};
            q_quo_in = {q_quo_ff[SUM_BITS-2:0], q_fits};
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
               state_in = BACK_DONE;
            end
         end
         BACK_DONE: begin
            if (out_ready) begin
               out_load = 1'b1;
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      div_ff    <= div_in;
      i_rem_ff  <= i_rem_in;
      q_rem_ff  <= q_rem_in;
      i_quo_ff  <= i_quo_in;
      q_quo_ff  <= q_quo_in;
      i_peak_ff <= i_peak_in;
      q_peak_ff <= q_peak_in;
   end

endmodule
`default_nettype wire

FILE: src/iq_peak_mean_power_meter.sv
// I/Q peak and mean power meter; depends on iqpm_pkg, iqpm_front, iqpm_job_fifo, iqpm_divider.
// Throughput: one sample word per cycle while the front end is not stalled; each closed window holds the divider, and
// the front end stalls when a window closes while the job queue already holds two windows.
// Result path: a closing sample's result reaches rsp_word through one accumulate stage, one job queue read,
// 57 divider steps and one output load, with the back end idle.
// Reset (synchronous): sums, peaks, count and queues cleared, window_limit = 4096000.
`default_nettype none
module iq_peak_mean_power_meter import iqpm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_word,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_word,
   input  logic                  csr_write,
   input  logic [LIMIT_BITS-1:0] csr_data
);

   logic [LIMIT_BITS-1:0] limit_ff, limit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic    job_push, job_full, job_pop, job_empty;
   job_type job_push_word, job_pop_word;
   logic    out_ready, out_load;
   rsp_type out_word;

   iqpm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_word     (req_word),
      .window_limit (limit_ff),
      .job_full     (job_full),
      .job_push     (job_push),
      .job_word     (job_push_word)
   );

   iqpm_job_fifo u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_word (job_push_word),
      .full      (job_full),
      .pop       (job_pop),
      .empty     (job_empty),
      .pop_word  (job_pop_word)
   );

   iqpm_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .job_word  (job_pop_word),
      .out_ready (out_ready),
      .out_load  (out_load),
      .out_word  (out_word)
   );

   // The output register frees up in the same cycle its word is popped.
   assign out_ready = !rsp_valid_ff || rsp_pop;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      limit_in     = csr_write ? csr_data : limit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = out_word;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_pop))
      else $error("divider overwrote a waiting result");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !job_empty)
      else $error("divider took a window from an empty job queue");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (out_word.window_count != '0))
      else $error("reported window has no samples");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !job_full)
      else $error("window pushed into a full job queue");

endmodule
`default_nettype wire

FILE: bench/iqpm_checker.sv
// Checker for the I/Q peak and mean power meter: watches the sample, result and
// register ports, predicts every closed window and compares it field by field.
// Depends on iqpm_pkg for the word types and the register reset value.
`timescale 1ns / 100ps
module iqpm_checker import iqpm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_full,
   input  req_type               req_word,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  rsp_type               rsp_word,
   input  logic                  csr_write,
   input  logic [LIMIT_BITS-1:0] csr_data,
   output int                    mismatch_count,
   output int                    windows_waiting,
   output int                    windows_checked
);

   logic [LIMIT_BITS-1:0] limit_copy;
   bit [63:0]             i_energy;
   bit [63:0]             q_energy;
   bit [POWER_BITS-1:0]   i_peak_seen;
   bit [POWER_BITS-1:0]   q_peak_seen;
   bit [COUNT_BITS-1:0]   samples_in_window;
   rsp_type               window_queue[$];
   int                    failures;
   int                    windows_done;

   function automatic bit [POWER_BITS-1:0] sample_power(logic signed [SAMPLE_BITS-1:0] s);
      longint v;
      v = s;
      if (v < 0) begin
         v = -v;
      end
      return POWER_BITS'(v * v);
   endfunction

   task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         failures++;
         if (failures <= 10) begin
            $display("%0t: window %0d, %s differs: expected %0d, got %0d",
                     $time, windows_done, field, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      bit [POWER_BITS-1:0] ip;
      bit [POWER_BITS-1:0] qp;
      rsp_type             want;
      if (reset) begin
         limit_copy        = LIMIT_RESET;
         i_energy          = '0;
         q_energy          = '0;
         i_peak_seen       = '0;
         q_peak_seen       = '0;
         samples_in_window = '0;
         window_queue.delete();
      end else begin
         if (csr_write) begin
            limit_copy = csr_data;
         end
         if (rsp_pop && !rsp_empty) begin
            if (window_queue.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display("%0t: result word with no window pending: %p", $time, rsp_word);
               end
            end else begin
               want = window_queue.pop_front();
               compare_field("i_peak_power", want.i_peak_power, rsp_word.i_peak_power);
               compare_field("q_peak_power", want.q_peak_power, rsp_word.q_peak_power);
               compare_field("i_mean_power", want.i_mean_power, rsp_word.i_mean_power);
               compare_field("q_mean_power", want.q_mean_power, rsp_word.q_mean_power);
               compare_field("window_count", want.window_count, rsp_word.window_count);
            end
            windows_done++;
         end
         if (req_push && !req_full) begin
            ip = sample_power(req_word.i_sample);
            qp = sample_power(req_word.q_sample);
            i_energy += ip;
            q_energy += qp;
            if (ip > i_peak_seen) begin
               i_peak_seen = ip;
            end
            if (qp > q_peak_seen) begin
               q_peak_seen = qp;
            end
            samples_in_window = samples_in_window + 1'b1;
            // The window closes on the first sample that takes the count past the limit.
            if (samples_in_window > limit_copy && samples_in_window != 0) begin
               want.i_peak_power = i_peak_seen;
               want.q_peak_power = q_peak_seen;
               want.i_mean_power = POWER_BITS'(i_energy / samples_in_window);
               want.q_mean_power = POWER_BITS'(q_energy / samples_in_window);
               want.window_count = samples_in_window;
               window_queue.push_back(want);
               i_energy          = '0;
               q_energy          = '0;
               i_peak_seen       = '0;
               q_peak_seen       = '0;
               samples_in_window = '0;
            end
         end
      end
      mismatch_count  <= failures;
      windows_waiting <= window_queue.size();
      windows_checked <= windows_done;
   end

endmodule

FILE: bench/tb_iq_peak_mean_power_meter.sv
// Top of the power meter bench: clock, reset, sample stimulus, result draining
// and register writes; the verdict comes from iqpm_checker.
// Depends on iqpm_pkg, iq_peak_mean_power_meter and iqpm_checker.
`timescale 1ns / 100ps
module tb_iq_peak_mean_power_meter;
   import iqpm_pkg::*;

   localparam int ITEM_TARGET    = 1950;
   localparam int TAIL_ITEMS     = 150;
   localparam int SETTLE_CYCLES  = 80;
   localparam int LONG_HOLD      = 400;
   localparam int PRESSURE_ITEMS = 80;
   localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = '1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   req_type               req_word = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   rsp_type               rsp_word;
   logic                  csr_write = 1'b0;
   logic [LIMIT_BITS-1:0] csr_data = '0;

   int mismatch_count;
   int windows_waiting;
   int windows_checked;
   int items_sent;
   int limits_written;
   bit steady_flow = 1'b0;
   bit drain_hold_req = 1'b0;
   bit drain_hold_done = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   iq_peak_mean_power_meter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_data  (csr_data)
   );

   iqpm_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_word        (req_word),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_word        (rsp_word),
      .csr_write       (csr_write),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .windows_waiting (windows_waiting),
      .windows_checked (windows_checked)
   );

   // Mostly full-range samples, with the corner values mixed in often.
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 11))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         3: return -16'sd1;
         default: return SAMPLE_BITS'($urandom_range(0, 65535));
      endcase
   endfunction

   // Push stays high after the word is taken, so back-to-back words need no toggle.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] i_value,
                              input logic signed [SAMPLE_BITS-1:0] q_value);
      if (!steady_flow && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_word <= '{i_sample: i_value, q_sample: q_value};
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   task automatic wait_all_windows();
      req_push <= 1'b0;
      do @(posedge clock); while (windows_waiting != 0);
      // A sample that closed no window may still be in the pipeline.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_limit(input logic [LIMIT_BITS-1:0] value);
      wait_all_windows();
      csr_write <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      limits_written++;
   endtask

   // Result side: random stall bursts, one long hold on request, none in the tail.
   initial begin : rsp_drain
      int unsigned span;
      forever begin
         @(posedge clock);
         if (drain_hold_req && !drain_hold_done) begin
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD - 1) @(posedge clock);
            drain_hold_done <= 1'b1;
         end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
            span = $urandom_range(1, 11);
            rsp_pop <= 1'b0;
            repeat (span - 1) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      #10ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int unsigned pick;
      int unsigned limit_value;
      int          span;
      bit          pressure_done;
      pressure_done = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default limit: corner samples build up a window without closing it.
      send_sample(-16'sd32768, 16'sd32767);
      send_sample(16'sd32767, -16'sd32768);
      send_sample(16'sd0, 16'sd0);
      send_sample(-16'sd1, 16'sd1);
      send_sample(16'sd1, -16'sd1);
      send_sample(-16'sd32768, -16'sd32768);
      set_limit(LIMIT_MAX);
      send_sample(16'sd32767, 16'sd0);
      send_sample(16'sd0, -16'sd32768);
      // Dropping the limit under the running count closes the window on the next word.
      set_limit(LIMIT_BITS'(1));
      send_sample(-16'sd32768, -16'sd32768);
      send_sample(16'sd0, 16'sd0);
      send_sample(16'sd0, 16'sd0);
      send_sample(16'sd32767, -16'sd32768);
      send_sample(-16'sd32768, 16'sd32767);
      set_limit(LIMIT_BITS'(2));
      send_sample(16'sd1, -16'sd1);
      send_sample(-16'sd1, 16'sd1);
      send_sample(16'sd0, 16'sd0);
      repeat (3) send_sample(-16'sd32768, -16'sd32768);

      while (items_sent < ITEM_TARGET) begin
         if (!pressure_done && items_sent > 600) begin
            // Hold the result side while words keep coming, so the input stalls.
            set_limit(LIMIT_BITS'(1));
            steady_flow    <= 1'b1;
            drain_hold_req <= 1'b1;
            repeat (PRESSURE_ITEMS) send_sample(pick_sample(), pick_sample());
            steady_flow   <= 1'b0;
            pressure_done = 1'b1;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               limit_value = 1;
            end else if (pick == 1) begin
               limit_value = $urandom_range(100, 300);
            end else begin
               limit_value = $urandom_range(2, 40);
            end
            span = $urandom_range(40, 120);
            if (items_sent + span > ITEM_TARGET) begin
               span = ITEM_TARGET - items_sent;
            end
            set_limit(LIMIT_BITS'(limit_value));
            if (ITEM_TARGET - items_sent <= TAIL_ITEMS + span) begin
               steady_flow <= 1'b1;
            end
            repeat (span) send_sample(pick_sample(), pick_sample());
         end
      end

      wait_all_windows();
      $display("Covered %0d sample words under %0d window limit settings;",
               items_sent, limits_written);
      $display("%0d closed power windows were checked against the prediction.",
               windows_checked);
      if (mismatch_count == 0 && windows_waiting == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
